>>> design/ctq_pkg.sv
// ctq_pkg: shared types and constants of the capacitive touch qualifier
// request codes, result codes, register indexes, command characters, reset values
// no dependencies
`timescale 1ns / 1ps

package ctq_pkg;

    // request kinds
    localparam logic [1:0] REQ_MEAS  = 2'd0;
    localparam logic [1:0] REQ_CALIB = 2'd1;
    localparam logic [1:0] REQ_CMD   = 2'd2;

    // edge codes
    localparam logic [1:0] EDGE_NONE    = 2'd0;
    localparam logic [1:0] EDGE_PRESS   = 2'd1;
    localparam logic [1:0] EDGE_RELEASE = 2'd2;

    // configuration register indexes
    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 16;
    localparam logic [1:0]  CFG_DELTA     = 2'd0;
    localparam logic [1:0]  CFG_DEBOUNCE  = 2'd1;
    localparam logic [1:0]  CFG_MIN_THR   = 2'd2;
    localparam logic [1:0]  CFG_MAX_THR   = 2'd3;

    // configuration reset values
    localparam logic [15:0] DELTA_RST     = 16'd100;
    localparam logic [7:0]  DEBOUNCE_RST  = 8'd1;
    localparam logic [15:0] MIN_THR_RST   = 16'd100;
    localparam logic [15:0] MAX_THR_RST   = 16'd5000;

    // command line characters and layout
    localparam logic [7:0]  CH_T          = 8'h54;
    localparam logic [7:0]  CH_H          = 8'h48;
    localparam logic [7:0]  CH_R          = 8'h52;
    localparam logic [7:0]  CH_COLON      = 8'h3A;
    localparam logic [7:0]  CH_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CH_ZERO       = 8'h30;
    localparam logic [7:0]  CH_NINE       = 8'h39;
    localparam int          POS_T         = 0;
    localparam int          POS_H         = 1;
    localparam int          POS_R         = 2;
    localparam int          POS_COLON     = 9;
    localparam int          POS_DIGITS    = 10;
    localparam int          NUM_W         = 17;
    localparam logic [16:0] NUM_SAT       = 17'h1FFFF;

    // per-item results of the sub-units
    typedef struct packed {
        logic        raw;
        logic        stable;
        logic [1:0]  edge_code;
    } t_deb_res;

    typedef struct packed {
        logic        done;
        logic [15:0] thr;
    } t_cal_res;

    typedef struct packed {
        logic        ack;
        logic [15:0] thr;
    } t_cmd_res;

endpackage

>>> design/capacitive_touch_qualifier_unit.sv
// capacitive_touch_qualifier_unit: top level with input word register, threshold,
// configuration registers and result register; uses ctq_pkg, ctq_debounce,
// ctq_calib and ctq_cmd_parser
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid / o_ready) carries one word: a measurement count, a
//   calibration count or one command character, chosen by i_req_type. Every
//   word gives exactly one result word on the output channel (o_valid / i_ready).
//   Configuration writes (i_cfg_valid / o_cfg_ready, always ready) set delta,
//   debounce count and the command threshold bounds; write them only when the
//   block holds no word in flight.
// Flow and throughput
//   A word is captured in the input register and processed combinationally
//   into the result register once that register is empty or its word is taken.
//   One word per cycle is sustained while i_ready is high; o_ready depends
//   on i_ready only while both registers are full.
//   The calibration average uses one combinational reciprocal multiply.
// Reset
//   i_rst_n (synchronous, low) clears the pipeline, the debounce and calibration
//   state, the command line and the threshold, and loads register defaults.
// Stall
//   While i_ready is low the result holds; the input register still takes one
//   more word, then o_ready drops until the result is taken.
module capacitive_touch_qualifier_unit #(
    parameter int CALIB_SAMPLES = 50,
    parameter int LINE_CHARS    = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input words
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_req_type,
    input  logic [15:0]                      i_sample,
    input  logic [7:0]                       i_rx_byte,
    // result words
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic                             o_below_thr,
    output logic                             o_touch_state,
    output logic [1:0]                       o_edge_res,
    output logic [15:0]                      o_threshold,
    output logic                             o_ack,
    output logic                             o_cal_complete,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [ctq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [ctq_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import ctq_pkg::*;

    logic        r_s1_valid;
    logic [1:0]  r_s1_type;
    logic [15:0] r_s1_sample;
    logic [7:0]  r_s1_byte;
    logic [15:0] r_thr;
    logic [15:0] r_delta;
    logic [7:0]  r_debounce;
    logic [15:0] r_min_thr;
    logic [15:0] r_max_thr;
    logic        r_out_valid;
    logic        r_raw;
    logic        r_stable;
    logic [1:0]  r_edge;
    logic [15:0] r_out_thr;
    logic        r_ack;
    logic        r_done;
    logic [15:0] n_thr;
    logic        adv;
    logic        calib_busy;
    t_deb_res    deb_res;
    t_cal_res    cal_res;
    t_cmd_res    cmd_res;

    // pipeline flow
    assign adv         = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || adv;
    assign o_cfg_ready = 1'b1;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_type   <= i_req_type;
            r_s1_sample <= i_sample;
            r_s1_byte   <= i_rx_byte;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta    <= DELTA_RST;
            r_debounce <= DEBOUNCE_RST;
            r_min_thr  <= MIN_THR_RST;
            r_max_thr  <= MAX_THR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DELTA:    r_delta    <= i_cfg_data;
                CFG_DEBOUNCE: r_debounce <= i_cfg_data[7:0];
                CFG_MIN_THR:  r_min_thr  <= i_cfg_data;
                CFG_MAX_THR:  r_max_thr  <= i_cfg_data;
            endcase
        end
    end

    ctq_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_active         (r_s1_type == REQ_MEAS),
        .i_adv            (adv),
        .i_sample         (r_s1_sample),
        .i_threshold      (r_thr),
        .i_debounce_count (r_debounce),
        .o_res            (deb_res)
    );

    ctq_calib #(
        .CALIB_SAMPLES (CALIB_SAMPLES)
    ) u_calib (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (r_s1_type == REQ_CALIB),
        .i_adv    (adv),
        .i_sample (r_s1_sample),
        .i_delta  (r_delta),
        .o_busy   (calib_busy),
        .o_res    (cal_res)
    );

    ctq_cmd_parser #(
        .LINE_CHARS (LINE_CHARS)
    ) u_cmd (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_active        (r_s1_type == REQ_CMD),
        .i_adv           (adv),
        .i_rx_byte       (r_s1_byte),
        .i_calibrating   (calib_busy),
        .i_min_threshold (r_min_thr),
        .i_max_threshold (r_max_thr),
        .o_res           (cmd_res)
    );

    // threshold after this word
    always_comb begin
        n_thr = r_thr;
        if (cal_res.done) begin
            n_thr = cal_res.thr;
        end else if (cmd_res.ack) begin
            n_thr = cmd_res.thr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 16'd0;
        end else if (adv) begin
            r_thr <= n_thr;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_raw     <= deb_res.raw;
            r_stable  <= deb_res.stable;
            r_edge    <= deb_res.edge_code;
            r_out_thr <= n_thr;
            r_ack     <= cmd_res.ack;
            r_done    <= cal_res.done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_below_thr    = r_raw;
    assign o_touch_state  = r_stable;
    assign o_edge_res     = r_edge;
    assign o_threshold    = r_out_thr;
    assign o_ack          = r_ack;
    assign o_cal_complete = r_done;

endmodule

>>> design/ctq_debounce.sv
// ctq_debounce: threshold compare, debounce counter and edge report
// depends on ctq_pkg
`timescale 1ns / 1ps

module ctq_debounce (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_active,
    input  logic              i_adv,
    input  logic [15:0]       i_sample,
    input  logic [15:0]       i_threshold,
    input  logic [7:0]        i_debounce_count,
    output ctq_pkg::t_deb_res o_res
);
    import ctq_pkg::*;

    logic       r_prev_raw;
    logic       r_stable;
    logic [7:0] r_ctr;
    logic       n_prev_raw;
    logic       n_stable;
    logic [7:0] n_ctr;
    logic       raw;

    // next debounce state for a measurement word
    always_comb begin
        raw        = (i_sample < i_threshold);
        n_prev_raw = r_prev_raw;
        n_stable   = r_stable;
        n_ctr      = r_ctr;
        if (raw != r_prev_raw) begin
            n_ctr      = 8'd0;
            n_prev_raw = raw;
        end else begin
            if (r_ctr != 8'hFF) begin
                n_ctr = r_ctr + 8'd1;
            end
            if (n_ctr >= i_debounce_count) begin
                n_stable = raw;
            end
        end
    end

    // result of this word
    always_comb begin
        o_res.raw       = i_active & raw;
        o_res.stable    = i_active ? n_stable : r_stable;
        o_res.edge_code = EDGE_NONE;
        if (i_active && n_stable && !r_stable) begin
            o_res.edge_code = EDGE_PRESS;
        end else if (i_active && !n_stable && r_stable) begin
            o_res.edge_code = EDGE_RELEASE;
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= 1'b0;
            r_stable   <= 1'b0;
            r_ctr      <= 8'd0;
        end else if (i_adv && i_active) begin
            r_prev_raw <= n_prev_raw;
            r_stable   <= n_stable;
            r_ctr      <= n_ctr;
        end
    end

endmodule

>>> design/ctq_calib.sv
// ctq_calib: calibration accumulator, average by reciprocal multiply, delta offset
// depends on ctq_pkg
`timescale 1ns / 1ps

module ctq_calib #(
    parameter int CALIB_SAMPLES = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_active,
    input  logic              i_adv,
    input  logic [15:0]       i_sample,
    input  logic [15:0]       i_delta,
    output logic              o_busy,
    output ctq_pkg::t_cal_res o_res
);
    import ctq_pkg::*;

    localparam int CNT_W  = $clog2(CALIB_SAMPLES + 1);
    localparam int SUM_W  = 16 + CNT_W;
    localparam int SHIFT  = SUM_W + CNT_W;
    localparam int MULT_W = SHIFT + 1;
    localparam logic [MULT_W-1:0] MULT =
        MULT_W'(((64'd1 << SHIFT) + 64'(CALIB_SAMPLES) - 64'd1) / 64'(CALIB_SAMPLES));
    localparam logic [CNT_W-1:0] LAST = CNT_W'(CALIB_SAMPLES);

    logic [SUM_W-1:0]        r_sum;
    logic [CNT_W-1:0]        r_seen;
    logic [SUM_W-1:0]        n_sum;
    logic [CNT_W-1:0]        n_seen;
    logic [SUM_W+MULT_W-1:0] prod;
    logic [15:0]             avg;
    logic                    full;

    // running sum and truncating average (exact for every reachable sum)
    always_comb begin
        n_sum  = r_sum + SUM_W'(i_sample);
        n_seen = r_seen + CNT_W'(1);
        full   = (n_seen == LAST);
        prod   = (SUM_W+MULT_W)'(n_sum) * (SUM_W+MULT_W)'(MULT);
        avg    = prod[SHIFT +: 16];
    end

    assign o_busy    = (r_seen != '0);
    assign o_res.done = i_active & full;
    assign o_res.thr  = (avg > i_delta) ? (avg - i_delta) : 16'd0;

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_seen <= '0;
        end else if (i_adv && i_active) begin
            if (full) begin
                r_sum  <= '0;
                r_seen <= '0;
            end else begin
                r_sum  <= n_sum;
                r_seen <= n_seen;
            end
        end
    end

endmodule

>>> design/ctq_cmd_parser.sv
// ctq_cmd_parser: command line scanner for "THR" + six chars + ':' + digits
// depends on ctq_pkg
`timescale 1ns / 1ps

module ctq_cmd_parser #(
    parameter int LINE_CHARS = 15
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_active,
    input  logic              i_adv,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_calibrating,
    input  logic [15:0]       i_min_threshold,
    input  logic [15:0]       i_max_threshold,
    output ctq_pkg::t_cmd_res o_res
);
    import ctq_pkg::*;

    localparam int POS_W = $clog2(LINE_CHARS + 1);

    logic [POS_W-1:0] r_pos;
    logic             r_hdr_ok;
    logic [NUM_W-1:0] r_num;
    logic             r_digits_end;
    logic [POS_W-1:0] n_pos;
    logic             n_hdr_ok;
    logic [NUM_W-1:0] n_num;
    logic             n_digits_end;
    logic             is_nl;
    logic             is_digit;
    logic [NUM_W+3:0] num_x10;

    // next line state for one received character
    always_comb begin
        is_nl        = (i_rx_byte == CH_NEWLINE);
        is_digit     = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
        num_x10      = ({r_num, 3'b000} + {2'b00, r_num, 1'b0})
                       + (NUM_W+4)'(i_rx_byte - CH_ZERO);
        n_pos        = r_pos;
        n_hdr_ok     = r_hdr_ok;
        n_num        = r_num;
        n_digits_end = r_digits_end;
        if (is_nl) begin
            n_pos        = '0;
            n_hdr_ok     = 1'b1;
            n_num        = '0;
            n_digits_end = 1'b0;
        end else if (r_pos < POS_W'(LINE_CHARS)) begin
            if ((r_pos == POS_W'(POS_T)     && i_rx_byte != CH_T) ||
                (r_pos == POS_W'(POS_H)     && i_rx_byte != CH_H) ||
                (r_pos == POS_W'(POS_R)     && i_rx_byte != CH_R) ||
                (r_pos == POS_W'(POS_COLON) && i_rx_byte != CH_COLON)) begin
                n_hdr_ok = 1'b0;
            end
            if (r_pos >= POS_W'(POS_DIGITS) && !r_digits_end) begin
                if (is_digit) begin
                    n_num = (num_x10 > (NUM_W+4)'(NUM_SAT)) ? NUM_SAT
                                                            : num_x10[NUM_W-1:0];
                end else begin
                    n_digits_end = 1'b1;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    // line accepted at its newline
    assign o_res.ack = i_active && is_nl && !i_calibrating &&
                       (r_pos >= POS_W'(POS_DIGITS)) && r_hdr_ok &&
                       (r_num > NUM_W'(i_min_threshold)) &&
                       (r_num < NUM_W'(i_max_threshold));
    assign o_res.thr = r_num[15:0];

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_hdr_ok     <= 1'b1;
            r_num        <= '0;
            r_digits_end <= 1'b0;
        end else if (i_adv && i_active) begin
            r_pos        <= n_pos;
            r_hdr_ok     <= n_hdr_ok;
            r_num        <= n_num;
            r_digits_end <= n_digits_end;
        end
    end

endmodule
